FILE: rtl/pngdf_pkg.sv
package pngdf_pkg;

  localparam int unsigned ResultDepthDefault = 4;
  localparam int unsigned HdrBytes = 4;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_CRC,
    PH_DONE
  } phase_e;

  typedef enum logic {
    KIND_PAYLOAD,
    KIND_VERDICT
  } kind_e;

  typedef enum logic [1:0] {
    VERDICT_OK,
    VERDICT_MISMATCH,
    VERDICT_TRUNC
  } verdict_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    verdict_e    verdict;
    logic [31:0] chunk_length;
    logic [31:0] chunk_type;
    logic [31:0] computed_crc;
    logic        run_last;
  } result_t;

  // up to two results per accepted word
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef logic [31:0] crc_tab_t [256];

  function automatic crc_tab_t crc_table_build();
    crc_tab_t    tab;
    logic [31:0] t;
    for (int i = 0; i < 256; i++) begin
      t = 32'(i);
      for (int k = 0; k < 8; k++) begin
        t = t[0] ? (CrcPoly ^ (t >> 1)) : (t >> 1);
      end
      tab[i] = t;
    end
    return tab;
  endfunction

  localparam crc_tab_t CrcTable = crc_table_build();

endpackage

FILE: rtl/pngdf_parser.sv
module pngdf_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [7:0]       data_byte_i,
  input  logic             frame_end_i,
  output pngdf_pkg::push_t push_o
);

  pngdf_pkg::phase_e phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rx_q, rx_d;

  logic [31:0] cnt_inc;
  logic [31:0] crc_upd;
  logic [31:0] crc_fin;
  logic        hdr_done;
  logic        data_done;

  assign cnt_inc   = cnt_q + 32'd1;
  assign hdr_done  = (cnt_inc >= 32'(pngdf_pkg::HdrBytes));
  assign data_done = (cnt_inc >= len_q);
  assign crc_upd   = pngdf_pkg::CrcTable[crc_q[7:0] ^ data_byte_i] ^ {8'h00, crc_q[31:8]};

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      pngdf_pkg::PH_LEN: begin
        if (hdr_done) phase_d = pngdf_pkg::PH_TYPE;
      end
      pngdf_pkg::PH_TYPE: begin
        if (hdr_done) phase_d = (len_q == 32'd0) ? pngdf_pkg::PH_CRC : pngdf_pkg::PH_DATA;
      end
      pngdf_pkg::PH_DATA: begin
        if (data_done) phase_d = pngdf_pkg::PH_CRC;
      end
      pngdf_pkg::PH_CRC: begin
        if (hdr_done) phase_d = pngdf_pkg::PH_DONE;
      end
      default: phase_d = phase_q;
    endcase
    if (frame_end_i) phase_d = pngdf_pkg::PH_LEN;
  end

  // datapath and results
  always_comb begin
    pngdf_pkg::result_t pay_res;
    pngdf_pkg::result_t ver_res;
    logic               pay_vld;
    logic               ver_vld;
    logic               verdict_given;

    cnt_d         = cnt_inc;
    len_d         = len_q;
    type_d        = type_q;
    crc_d         = crc_q;
    rx_d          = rx_q;
    pay_vld       = 1'b0;
    ver_vld       = 1'b0;
    verdict_given = 1'b0;
    ver_res       = '0;
    ver_res.kind  = pngdf_pkg::KIND_VERDICT;

    case (phase_q)
      pngdf_pkg::PH_LEN: begin
        len_d = {len_q[23:0], data_byte_i};
        if (hdr_done) cnt_d = '0;
      end
      pngdf_pkg::PH_TYPE: begin
        type_d = {type_q[23:0], data_byte_i};
        crc_d  = crc_upd;
        if (hdr_done) cnt_d = '0;
      end
      pngdf_pkg::PH_DATA: begin
        crc_d   = crc_upd;
        pay_vld = 1'b1;
        if (data_done) cnt_d = '0;
      end
      pngdf_pkg::PH_CRC: begin
        rx_d = {rx_q[23:0], data_byte_i};
        if (hdr_done) begin
          cnt_d         = '0;
          ver_vld       = 1'b1;
          verdict_given = 1'b1;
        end
      end
      default: begin
        cnt_d         = cnt_q;
        verdict_given = 1'b1;
      end
    endcase

    crc_fin = crc_d ^ pngdf_pkg::CrcOnes;

    pay_res              = '0;
    pay_res.kind         = pngdf_pkg::KIND_PAYLOAD;
    pay_res.payload_byte = data_byte_i;
    pay_res.chunk_length = len_d;
    pay_res.chunk_type   = type_d;

    ver_res.chunk_length = len_d;
    ver_res.chunk_type   = type_d;
    ver_res.computed_crc = crc_fin;
    ver_res.verdict      = (crc_fin == rx_d) ? pngdf_pkg::VERDICT_OK
                                             : pngdf_pkg::VERDICT_MISMATCH;

    if (frame_end_i) begin
      if (!verdict_given) begin
        ver_vld         = 1'b1;
        ver_res.verdict = pngdf_pkg::VERDICT_TRUNC;
      end
      cnt_d  = '0;
      len_d  = '0;
      type_d = '0;
      crc_d  = pngdf_pkg::CrcOnes;
      rx_d   = '0;
    end

    push_o = '0;
    if (pay_vld && ver_vld) begin
      ver_res.run_last = 1'b1;
      push_o.count  = 2'd2;
      push_o.first  = pay_res;
      push_o.second = ver_res;
    end else if (pay_vld) begin
      pay_res.run_last = 1'b1;
      push_o.count = 2'd1;
      push_o.first = pay_res;
    end else if (ver_vld) begin
      ver_res.run_last = 1'b1;
      push_o.count = 2'd1;
      push_o.first = ver_res;
    end
    if (!in_fire_i) push_o.count = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pngdf_pkg::PH_LEN;
      cnt_q   <= '0;
      len_q   <= '0;
      type_q  <= '0;
      crc_q   <= pngdf_pkg::CrcOnes;
      rx_q    <= '0;
    end else if (in_fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      type_q  <= type_d;
      crc_q   <= crc_d;
      rx_q    <= rx_d;
    end
  end

endmodule

FILE: rtl/pngdf_result_fifo.sv
module pngdf_result_fifo #(
  parameter int unsigned Depth = pngdf_pkg::ResultDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pngdf_pkg::push_t   push_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               stall_i,
  output pngdf_pkg::result_t res_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pngdf_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_nxt;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_nxt  = ptr_inc(wr_ptr_q);
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign res_o   = mem_q[rd_ptr_q];
  // room for two results must be there before a word is taken
  assign full_o  = (cnt_q > CntW'(Depth - 2));

  always_comb begin
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    case (push_i.count)
      2'd1:    wr_ptr_d = wr_nxt;
      2'd2:    wr_ptr_d = ptr_inc(wr_nxt);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr_nxt]   <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: rtl/png_chunk_deframer_crc_check_core.sv
// Channel   Direction  Handshake                Payload
// in        sink       in_valid_i / in_stall_o  data_byte_i, frame_end_i
// out       source     out_valid_o / out_stall_i kind_o, payload_byte_o, verdict_o,
//                                               chunk_length_o, chunk_type_o,
//                                               computed_crc_o, run_last_o
//
// One word per cycle while in_stall_o is low: header/CRC parsing and the table CRC
// update sit between the state registers and a small result queue. A word gives at
// most two results; the queue sends them out one at a time, so a word that yields a
// payload byte and a truncation verdict gives two result words.
// Reset clears the parser to the length phase with the CRC at all ones.
// in_stall_o rises while the queue cannot take two more results.
module png_chunk_deframer_crc_check_core #(
  parameter int unsigned ResultDepth = pngdf_pkg::ResultDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [1:0]  verdict_o,
  output logic [31:0] chunk_length_o,
  output logic [31:0] chunk_type_o,
  output logic [31:0] computed_crc_o,
  output logic        run_last_o
);

  logic               in_fire;
  pngdf_pkg::push_t   push;
  pngdf_pkg::result_t res;

  assign in_fire = in_valid_i && !in_stall_o;

  pngdf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .push_o      (push)
  );

  pngdf_result_fifo #(
    .Depth (ResultDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (in_stall_o),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (res)
  );

  assign kind_o         = res.kind;
  assign payload_byte_o = res.payload_byte;
  assign verdict_o      = res.verdict;
  assign chunk_length_o = res.chunk_length;
  assign chunk_type_o   = res.chunk_type;
  assign computed_crc_o = res.computed_crc;
  assign run_last_o     = res.run_last;

endmodule

FILE: rtl/pngdf_checker.sv
module pngdf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  data_byte_i,
  input logic        frame_end_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [1:0]  verdict_o,
  input logic [31:0] chunk_length_o,
  input logic [31:0] chunk_type_o,
  input logic [31:0] computed_crc_o,
  input logic        run_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(kind_o) && $stable(payload_byte_o) &&
      $stable(verdict_o) && $stable(computed_crc_o) && $stable(run_last_o))
    else $error("stalled result word changed");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == pngdf_pkg::KIND_PAYLOAD |->
      verdict_o == pngdf_pkg::VERDICT_OK && computed_crc_o == 32'd0)
    else $error("payload word carries verdict fields");

  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == pngdf_pkg::KIND_VERDICT |->
      run_last_o && payload_byte_o == 8'd0)
    else $error("verdict word not last of its run");

endmodule

bind png_chunk_deframer_crc_check_core pngdf_checker u_pngdf_checker (.*);
